/* rtl/core/gta_pkg.sv */
// Shared types and constants of the glyph transition animator.
package gta_pkg;

	localparam logic       FUNC_SET  = 1'b0;
	localparam logic       FUNC_TICK = 1'b1;

	localparam logic [2:0] KIND_UP    = 3'd0;
	localparam logic [2:0] KIND_DOWN  = 3'd1;
	localparam logic [2:0] KIND_LEFT  = 3'd2;
	localparam logic [2:0] KIND_RIGHT = 3'd3;

	localparam logic [4:0] STEP_IDLE  = 5'd31;
	localparam logic [4:0] VERT_STEPS = 5'd8;
	localparam logic [4:0] HORZ_STEPS = 5'd4;

	localparam int CHAR_W  = 8;
	localparam int GLYPH_W = 40;
	localparam int KIND_W  = 3;
	localparam int STEP_W  = 5;

	typedef struct packed {
		logic set_wr;
		logic rd_en;
		logic flush;
	} cmd_t;

endpackage

/* rtl/core/gta_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module gta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/gta_ctrl.sv */
// Controller state machine that sequences set beats and slot scans for ticks.
module gta_ctrl #(
	parameter int SLOTS = 16,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          func,
	output logic          busy,
	output gta_pkg::cmd_t cmd,
	output logic [AW-1:0] rd_addr
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

	state_t        state_q;
	logic [AW-1:0] idx_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && func == gta_pkg::FUNC_TICK) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy       = busy_q;
	assign cmd.set_wr = start && !busy_q && func == gta_pkg::FUNC_SET;
	assign cmd.rd_en  = state_q == ST_SCAN;
	assign cmd.flush  = state_q == ST_FLUSH;
	assign rd_addr    = idx_q;

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE))
		else $error("busy does not follow the controller state");

	a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && idx_q == LAST_IDX) |=> state_q == ST_DRAIN)
		else $error("scan did not stop after the last slot");

	a_flush_frees: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |=> !busy_q)
		else $error("controller stayed busy after flush");

endmodule

/* rtl/core/gta_datapath.sv */
// Slot storage, frame blending and result holding for the glyph animator.
module gta_datapath #(
	parameter int SLOTS = 16,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gta_pkg::cmd_t cmd,
	input  logic [AW-1:0] rd_addr,
	input  logic [3:0]    slot,
	input  logic [7:0]    char_code,
	input  logic [39:0]   glyph_columns,
	input  logic [2:0]    anim_type,
	input  logic          force_req,
	output logic          strobe,
	output logic [3:0]    out_slot,
	output logic [39:0]   frame_columns,
	output logic          last
);

	localparam int CUR_W = gta_pkg::CHAR_W + gta_pkg::GLYPH_W + gta_pkg::KIND_W;
	localparam int SH_W  = gta_pkg::CHAR_W + gta_pkg::GLYPH_W + gta_pkg::STEP_W;

	logic [31:0]      slot_ext;
	logic             cur_we;
	logic [AW-1:0]    wr_addr;
	logic [CUR_W-1:0] cur_rd;
	logic [SH_W-1:0]  sh_rd;
	logic [SH_W-1:0]  sh_wdata;
	logic             sh_we;

	logic [SLOTS-1:0] cur_vld_q;
	logic [SLOTS-1:0] sh_vld_q;
	logic [SLOTS-1:0] redraw_q;

	logic             vld_s1;
	logic [AW-1:0]    slot_s1;
	logic [31:0]      slot32_s1;

	logic [7:0]       cur_char;
	logic [39:0]      cur_glyph;
	logic [2:0]       cur_kind;
	logic [7:0]       sh_char;
	logic [39:0]      sh_glyph;
	logic [4:0]       sh_step;
	logic             active;
	logic [4:0]       step_nxt;
	logic [39:0]      up_frame;
	logic [39:0]      down_frame;
	logic [39:0]      left_frame;
	logic [39:0]      right_frame;
	logic [79:0]      left_all;
	logic [79:0]      right_all;
	logic             settle;
	logic [39:0]      frame;

	logic             pend_vld_q;
	logic [3:0]       pend_slot_q;
	logic [39:0]      pend_frame_q;
	logic             strobe_q;
	logic [3:0]       out_slot_q;
	logic [39:0]      frame_q;
	logic             last_q;

	assign slot_ext = 32'(slot);
	assign wr_addr  = slot_ext[AW-1:0];
	assign cur_we   = cmd.set_wr && (slot_ext < 32'(SLOTS));

	gta_ram #(.WIDTH(CUR_W), .DEPTH(SLOTS)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (wr_addr),
		.wdata ({char_code, glyph_columns, anim_type}),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (cur_rd)
	);

	gta_ram #(.WIDTH(SH_W), .DEPTH(SLOTS)) u_shown_ram (
		.clk   (clk),
		.we    (sh_we),
		.waddr (slot_s1),
		.wdata (sh_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (sh_rd)
	);

	// Entries never written read as their reset contents.
	always_comb begin
		if (cur_vld_q[slot_s1]) begin
			cur_char  = cur_rd[CUR_W-1 -: 8];
			cur_glyph = cur_rd[CUR_W-9 -: 40];
			cur_kind  = cur_rd[2:0];
		end else begin
			cur_char  = '0;
			cur_glyph = '0;
			cur_kind  = '0;
		end
		if (sh_vld_q[slot_s1]) begin
			sh_char  = sh_rd[SH_W-1 -: 8];
			sh_glyph = sh_rd[SH_W-9 -: 40];
			sh_step  = sh_rd[4:0];
		end else begin
			sh_char  = '0;
			sh_glyph = '0;
			sh_step  = gta_pkg::STEP_IDLE;
		end
	end

	assign active   = vld_s1 && ((cur_char != sh_char) || redraw_q[slot_s1]);
	assign step_nxt = sh_step + 5'd1;

	always_comb begin
		logic [15:0] up_pair;
		logic [15:0] down_pair;
		for (int j = 0; j < 5; j++) begin
			up_pair   = {sh_glyph[8*j +: 8], cur_glyph[8*j +: 8]} << step_nxt[2:0];
			down_pair = {cur_glyph[8*j +: 8], sh_glyph[8*j +: 8]} >> step_nxt[2:0];
			up_frame[8*j +: 8]   = up_pair[15:8];
			down_frame[8*j +: 8] = down_pair[7:0];
		end
	end

	assign left_all  = {cur_glyph, sh_glyph};
	assign right_all = {sh_glyph, cur_glyph};

	always_comb begin
		unique case (step_nxt[1:0])
			2'd0: begin
				left_frame  = left_all[47:8];
				right_frame = right_all[71:32];
			end
			2'd1: begin
				left_frame  = left_all[55:16];
				right_frame = right_all[63:24];
			end
			2'd2: begin
				left_frame  = left_all[63:24];
				right_frame = right_all[55:16];
			end
			2'd3: begin
				left_frame  = left_all[71:32];
				right_frame = right_all[47:8];
			end
			default: begin
				left_frame  = left_all[47:8];
				right_frame = right_all[71:32];
			end
		endcase
	end

	always_comb begin
		unique case (cur_kind)
			gta_pkg::KIND_UP: begin
				settle = step_nxt >= gta_pkg::VERT_STEPS;
				frame  = up_frame;
			end
			gta_pkg::KIND_DOWN: begin
				settle = step_nxt >= gta_pkg::VERT_STEPS;
				frame  = down_frame;
			end
			gta_pkg::KIND_LEFT: begin
				settle = step_nxt >= gta_pkg::HORZ_STEPS;
				frame  = left_frame;
			end
			gta_pkg::KIND_RIGHT: begin
				settle = step_nxt >= gta_pkg::HORZ_STEPS;
				frame  = right_frame;
			end
			default: begin
				settle = 1'b1;
				frame  = cur_glyph;
			end
		endcase
		if (settle) begin
			frame = cur_glyph;
		end
	end

	assign sh_we    = active;
	assign sh_wdata = settle ? {cur_char, cur_glyph, gta_pkg::STEP_IDLE}
	                         : {sh_char, sh_glyph, step_nxt};
	assign slot32_s1 = 32'(slot_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q  <= '0;
			sh_vld_q   <= '0;
			redraw_q   <= '0;
			vld_s1     <= 1'b0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			vld_s1   <= cmd.rd_en;
			strobe_q <= (active || cmd.flush) && pend_vld_q;
			if (cur_we) begin
				cur_vld_q[wr_addr] <= 1'b1;
				if (force_req) begin
					redraw_q[wr_addr] <= 1'b1;
				end
			end
			if (active) begin
				sh_vld_q[slot_s1] <= 1'b1;
				if (settle) begin
					redraw_q[slot_s1] <= 1'b0;
				end
				pend_vld_q <= 1'b1;
			end
			if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_s1_payload: begin
			slot_s1 <= rd_addr;
		end
		if (active) begin
			pend_slot_q  <= slot32_s1[3:0];
			pend_frame_q <= frame;
			out_slot_q   <= pend_slot_q;
			frame_q      <= pend_frame_q;
			last_q       <= 1'b0;
		end
		if (cmd.flush) begin
			out_slot_q <= pend_slot_q;
			frame_q    <= pend_frame_q;
			last_q     <= 1'b1;
		end
	end

	assign strobe        = strobe_q;
	assign out_slot      = out_slot_q;
	assign frame_columns = frame_q;
	assign last          = last_q;

	a_last_after_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> $past(cmd.flush))
		else $error("final beat of a tick not caused by a flush");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !pend_vld_q)
		else $error("pending frame survived the flush");

	a_no_set_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && cmd.set_wr))
		else $error("set beat written while a slot was being processed");

	a_flush_not_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.flush && vld_s1))
		else $error("flush overlapped a slot in process");

endmodule

/* rtl/core/glyph_transition_animator_unit.sv */
// Top level of the glyph transition animator: controller plus datapath.
//
// Usage: drive the item fields and raise start; a beat is taken at a clock edge
// where start is high and busy is low. A set beat (func low) stores one slot's
// character code, glyph, animation kind and force request and gives no result;
// busy stays low, so set beats may follow back to back.
// A tick beat (func high) raises busy and scans the slots in order, one slot
// per cycle through the slot memories; busy falls after the scan, a drain state
// and a flush state, after which the next beat may enter.
// Each active slot gives one result beat: strobe is high for exactly one cycle
// with out_slot, frame_columns and last. Results come out in slot order, at
// most one per cycle, each held until the next active slot or the flush;
// the final one, marked by last, appears in the first cycle with busy low again.
// A tick with no active slot gives no result.
// Reset clears all slot contents to zero and every step counter to idle; the
// result receiver has no way to stall, so strobe beats must be taken as shown.
module glyph_transition_animator_unit #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [3:0]  slot,
	input  logic [7:0]  char_code,
	input  logic [39:0] glyph_columns,
	input  logic [2:0]  anim_type,
	input  logic        force_req,
	output logic        strobe,
	output logic [3:0]  out_slot,
	output logic [39:0] frame_columns,
	output logic        last
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	gta_pkg::cmd_t cmd;
	logic [AW-1:0] rd_addr;

	gta_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.busy    (busy),
		.cmd     (cmd),
		.rd_addr (rd_addr)
	);

	gta_datapath #(.SLOTS(SLOTS)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.slot          (slot),
		.char_code     (char_code),
		.glyph_columns (glyph_columns),
		.anim_type     (anim_type),
		.force_req     (force_req),
		.strobe        (strobe),
		.out_slot      (out_slot),
		.frame_columns (frame_columns),
		.last          (last)
	);

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the glyph transition animator with a frame-predicting scoreboard.
`timescale 1ns / 1ps

module tb_top;

	localparam int SLOTS      = 16;
	localparam int GLYPH_COLS = 5;
	localparam int MAX_SHOWN  = 10;

	localparam logic [2:0] KIND_NONE = 3'd4;
	localparam logic [2:0] KIND_BAD  = 3'd7;

	typedef struct packed {
		logic [3:0]  slot;
		logic [39:0] cols;
		logic        last;
	} frame_beat_t;

	class glyph_anim_scoreboard;
		logic [7:0]  want_char[SLOTS];
		logic [7:0]  shown_char[SLOTS];
		logic [39:0] want_glyph[SLOTS];
		logic [39:0] shown_glyph[SLOTS];
		logic [4:0]  step[SLOTS];
		logic [2:0]  kind[SLOTS];
		bit          redraw[SLOTS];
		frame_beat_t due_q[$];
		int          errors;

		function void clear();
			for (int i = 0; i < SLOTS; i++) begin
				want_char[i]   = '0;
				shown_char[i]  = '0;
				want_glyph[i]  = '0;
				shown_glyph[i] = '0;
				step[i]        = gta_pkg::STEP_IDLE;
				kind[i]        = gta_pkg::KIND_UP;
				redraw[i]      = 1'b0;
			end
			due_q.delete();
			errors = 0;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function logic [39:0] blend_frame(logic [2:0] k, logic [4:0] s, logic [39:0] og,
				logic [39:0] ng, output bit settle);
			logic [15:0] o;
			logic [15:0] n;
			logic [15:0] t;
			logic [39:0] f;
			int sh;
			int kk;
			settle = 1'b0;
			f = '0;
			sh = int'(s);
			kk = int'(s) + 1;
			if (k == gta_pkg::KIND_UP || k == gta_pkg::KIND_DOWN) begin
				if (s >= gta_pkg::VERT_STEPS) begin
					settle = 1'b1;
				end else begin
					for (int j = 0; j < GLYPH_COLS; j++) begin
						o = {8'h00, og[8*j +: 8]};
						n = {8'h00, ng[8*j +: 8]};
						if (k == gta_pkg::KIND_UP) begin
							t = (o << sh) | (n >> (8 - sh));
						end else begin
							t = (o >> sh) | (n << (8 - sh));
						end
						f[8*j +: 8] = t[7:0];
					end
				end
			end else if (k == gta_pkg::KIND_LEFT || k == gta_pkg::KIND_RIGHT) begin
				if (s >= gta_pkg::HORZ_STEPS) begin
					settle = 1'b1;
				end else begin
					for (int j = 0; j < GLYPH_COLS; j++) begin
						if (k == gta_pkg::KIND_LEFT) begin
							if (j < GLYPH_COLS - kk) begin
								f[8*j +: 8] = og[8*(j + kk) +: 8];
							end else begin
								f[8*j +: 8] = ng[8*(j + kk - GLYPH_COLS) +: 8];
							end
						end else begin
							if (j < kk) begin
								f[8*j +: 8] = ng[8*(j + GLYPH_COLS - kk) +: 8];
							end else begin
								f[8*j +: 8] = og[8*(j - kk) +: 8];
							end
						end
					end
				end
			end else begin
				settle = 1'b1;
			end
			return f;
		endfunction

		function void note_beat(logic f, logic [3:0] sl, logic [7:0] ch, logic [39:0] g,
				logic [2:0] k, logic fr);
			int active;
			int made;
			bit settle;
			frame_beat_t b;
			active = 0;
			made = 0;
			if (f == gta_pkg::FUNC_SET) begin
				want_char[sl]  = ch;
				want_glyph[sl] = g;
				kind[sl]       = k;
				if (fr) begin
					redraw[sl] = 1'b1;
				end
				return;
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (want_char[i] != shown_char[i] || redraw[i]) begin
					active++;
				end
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (want_char[i] != shown_char[i] || redraw[i]) begin
					step[i] = step[i] + 5'd1;
					b.cols = blend_frame(kind[i], step[i], shown_glyph[i], want_glyph[i], settle);
					if (settle) begin
						step[i]        = gta_pkg::STEP_IDLE;
						redraw[i]      = 1'b0;
						shown_char[i]  = want_char[i];
						shown_glyph[i] = want_glyph[i];
						b.cols         = want_glyph[i];
					end
					made++;
					b.slot = i[3:0];
					b.last = (made == active);
					due_q.push_back(b);
				end
			end
		endfunction

		function void check_frame(logic [3:0] sl, logic [39:0] cols, logic lst);
			frame_beat_t b;
			if (due_q.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN) begin
					$display("mismatch: unexpected frame beat, slot %0d cols %h last %0b",
						sl, cols, lst);
				end
				return;
			end
			b = due_q.pop_front();
			if (b.slot !== sl || b.cols !== cols || b.last !== lst) begin
				errors++;
				if (errors <= MAX_SHOWN) begin
					$display("mismatch: slot exp %0d got %0d, cols exp %h got %h, last exp %0b got %0b",
						b.slot, sl, b.cols, cols, b.last, lst);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        func = 1'b0;
	logic [3:0]  slot = '0;
	logic [7:0]  char_code = '0;
	logic [39:0] glyph_columns = '0;
	logic [2:0]  anim_type = '0;
	logic        force_req = 1'b0;
	logic        strobe;
	logic [3:0]  out_slot;
	logic [39:0] frame_columns;
	logic        last;

	glyph_anim_scoreboard sb;
	int idle_pct = 34;

	glyph_transition_animator_unit #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.slot(slot),
		.char_code(char_code),
		.glyph_columns(glyph_columns),
		.anim_type(anim_type),
		.force_req(force_req),
		.strobe(strobe),
		.out_slot(out_slot),
		.frame_columns(frame_columns),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				sb.check_frame(out_slot, frame_columns, last);
			end
			if (start && !busy) begin
				sb.note_beat(func, slot, char_code, glyph_columns, anim_type, force_req);
			end
		end
	end

	task automatic send_beat(logic f, logic [3:0] sl, logic [7:0] ch, logic [39:0] g,
			logic [2:0] k, logic fr);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		func          <= f;
		slot          <= sl;
		char_code     <= ch;
		glyph_columns <= g;
		anim_type     <= k;
		force_req     <= fr;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_slot(logic [3:0] sl, logic [7:0] ch, logic [39:0] g, logic [2:0] k,
			logic fr);
		send_beat(gta_pkg::FUNC_SET, sl, ch, g, k, fr);
	endtask

	task automatic tick_beat();
		logic [39:0] g;
		g[31:0]  = $urandom;
		g[39:32] = 8'($urandom_range(255));
		send_beat(gta_pkg::FUNC_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)), g,
			3'($urandom_range(7)), 1'($urandom_range(1)));
	endtask

	task automatic random_set();
		logic [39:0] g;
		logic [7:0]  ch;
		logic [2:0]  k;
		g[31:0]  = $urandom;
		g[39:32] = 8'($urandom_range(255));
		ch = ($urandom_range(2) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
		k  = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		set_slot(4'($urandom_range(15)), ch, g, k, $urandom_range(3) == 0);
	endtask

	initial begin
		int items;
		int nsets;
		int nticks;
		sb = new;
		sb.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tick_beat();
		set_slot(4'd0, 8'hFF, 40'hFF_FFFF_FFFF, gta_pkg::KIND_UP, 1'b0);
		set_slot(4'd15, 8'h01, 40'h01_2345_6789, gta_pkg::KIND_DOWN, 1'b1);
		set_slot(4'd5, 8'h41, 40'hA5_5AF0_0F81, gta_pkg::KIND_LEFT, 1'b0);
		set_slot(4'd10, 8'h80, 40'hFF_00FF_00FF, gta_pkg::KIND_RIGHT, 1'b0);
		set_slot(4'd3, 8'h20, 40'h00_0000_007E, KIND_NONE, 1'b0);
		set_slot(4'd7, 8'h33, 40'h12_3456_789A, KIND_BAD, 1'b0);
		set_slot(4'd12, 8'h00, 40'h00_0000_001F, gta_pkg::KIND_LEFT, 1'b1);
		repeat (2) tick_beat();
		set_slot(4'd0, 8'hFF, 40'h00_FFFF_00FF, gta_pkg::KIND_RIGHT, 1'b0);
		set_slot(4'd5, 8'h00, 40'h00_0000_0000, gta_pkg::KIND_LEFT, 1'b0);
		repeat (10) tick_beat();
		set_slot(4'd5, 8'h41, 40'hC3_3C81_18E7, gta_pkg::KIND_DOWN, 1'b0);
		repeat (2) tick_beat();

		items = 0;
		while (items < 125) begin
			idle_pct = (items < 42) ? 34 : (items < 84) ? 84 : 0;
			nsets = $urandom_range(0, 4);
			repeat (nsets) random_set();
			nticks = $urandom_range(1, 10);
			repeat (nticks) tick_beat();
			items += nsets + nticks;
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
